>>> src/annexb_nal_unit_scanner_defines.svh
// assertion macros for the annex b nal unit scanner
// used by the top level only, no other dependencies
`ifndef ANNEXB_NAL_UNIT_SCANNER_DEFINES_SVH
`define ANNEXB_NAL_UNIT_SCANNER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define ANXB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scanner check failed");

// next-cycle implication, disabled during reset
`define ANXB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scanner check failed");

`endif

>>> src/anxb_pkg.sv
// shared types, constants and helper functions of the annex b nal unit scanner
// no dependencies
package anxb_pkg;

    localparam int LENGTH_WIDTH = 24;
    localparam int HELD_W       = LENGTH_WIDTH + 1;
    localparam int UNIT_LEN_W   = 24;

    localparam logic [HELD_W-1:0] LEN_MAX = {1'b0, {LENGTH_WIDTH{1'b1}}};

    localparam logic [7:0] FORBIDDEN_MASK = 8'h80;
    localparam logic [7:0] IDC_MASK       = 8'h60;
    localparam logic [7:0] TYPE_MASK      = 8'h1f;

    localparam logic [23:0] RECENT_RESET = 24'hffffff;
    localparam logic [7:0]  START_BYTE   = 8'h01;
    localparam logic [2:0]  PLEN_3       = 3'd3;
    localparam logic [2:0]  PLEN_4       = 3'd4;

    localparam logic [1:0]  QUEUE_DEPTH  = 2'd3;

    typedef enum logic [1:0] {
        PH_AWAIT,
        PH_UNIT,
        PH_STOP
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } byte_beat_t;

    typedef struct packed {
        logic [31:0]           unit_number;
        logic [31:0]           unit_offset;
        logic [2:0]            prefix_length;
        logic [UNIT_LEN_W-1:0] unit_length;
        logic                  forbidden_flag;
        logic [1:0]            reference_idc;
        logic [4:0]            unit_type;
        logic                  stream_error;
        logic                  last_of_run;
    } rec_t;

    // results of one scan step handed to the result queue
    typedef struct packed {
        logic [1:0] n;
        rec_t       rec0;
        rec_t       rec1;
    } push_t;

    function automatic logic [LENGTH_WIDTH-1:0] sat_len(input logic [HELD_W-1:0] v);
        logic [HELD_W-1:0] s;
        s = (v > LEN_MAX) ? LEN_MAX : v;
        return s[LENGTH_WIDTH-1:0];
    endfunction

    function automatic rec_t make_rec(input logic [31:0]             number,
                                      input logic [31:0]             offset,
                                      input logic [2:0]              plen,
                                      input logic [LENGTH_WIDTH-1:0] len,
                                      input logic [7:0]              hdr);
        rec_t        r;
        logic [7:0]  h;
        logic [7:0]  idc;
        logic [31:0] wide_len;
        h        = (len == '0) ? 8'h00 : hdr;
        idc      = (h & IDC_MASK) >> 5;
        wide_len = 32'(len);
        r.unit_number    = number;
        r.unit_offset    = offset;
        r.prefix_length  = plen;
        r.unit_length    = wide_len[UNIT_LEN_W-1:0];
        r.forbidden_flag = (h & FORBIDDEN_MASK) != 8'h00;
        r.reference_idc  = idc[1:0];
        r.unit_type      = 5'(h & TYPE_MASK);
        r.stream_error   = 1'b0;
        r.last_of_run    = 1'b0;
        return r;
    endfunction

endpackage

>>> src/anxb_byte_if.sv
// valid/ready channel carrying one stream byte per beat
// depends on anxb_pkg
interface anxb_byte_if;
    import anxb_pkg::*;

    logic       valid;
    logic       ready;
    byte_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> src/anxb_rec_if.sv
// valid/ready channel carrying one nal unit record per beat
// depends on anxb_pkg
interface anxb_rec_if;
    import anxb_pkg::*;

    logic valid;
    logic ready;
    rec_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> src/annexb_nal_unit_scanner.sv
// top level of the annex b nal unit scanner: scan core plus result queue
// depends on anxb_pkg, anxb_byte_if, anxb_rec_if, anxb_core, anxb_out_queue
//
// usage
//   stream: one annex b byte per beat, end_of_stream marks the final byte
//   units:  one record per closed nal unit, or one error record if the
//           stream does not open with a start code
//   a byte is registered on acceptance and scanned once the queue has room;
//   its records are written into the result queue and offered on units in
//   the cycle after the scan
//   throughput is one byte per cycle while units is ready, set by the scan
//   step and the three-entry result queue; the final byte may give two
//   records, which leave one at a time
//   when units stalls, the queue fills and stream.ready drops once two
//   records wait; nothing is lost
//   reset clears all state but stored data: the scanner waits for the
//   opening start code at stream position zero; after the final byte or
//   an error record every byte is taken and ignored until the next reset
`include "annexb_nal_unit_scanner_defines.svh"

module annexb_nal_unit_scanner (
    input logic        clk,
    input logic        rst_n,
    anxb_byte_if.sink  stream,
    anxb_rec_if.source units
);
    import anxb_pkg::*;

    push_t push;
    logic  room;

    anxb_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream),
        .room   (room),
        .push   (push)
    );

    anxb_out_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .room  (room),
        .units (units)
    );

    `ANXB_ASSERT_IMP(a_push_has_room, clk, rst_n, push.n != 2'd0, room)
    `ANXB_ASSERT_IMP(a_pair_last, clk, rst_n, push.n == 2'd2,
                     !push.rec0.last_of_run && push.rec1.last_of_run)
    `ANXB_ASSERT_IMP(a_error_rec, clk, rst_n, units.valid && units.data.stream_error,
                     units.data.last_of_run && units.data.unit_number == 32'd0)
    `ANXB_ASSERT_NXT(a_quiet_after_end, clk, rst_n,
                     push.n != 2'd0 && push.rec0.stream_error, push.n == 2'd0)

endmodule

>>> src/anxb_core.sv
// input register and start code scan step with all unit state
// depends on anxb_pkg and anxb_byte_if
module anxb_core (
    input  logic            clk,
    input  logic            rst_n,
    anxb_byte_if.sink       stream,
    input  logic            room,
    output anxb_pkg::push_t push
);
    import anxb_pkg::*;

    logic                    in_valid_reg, in_valid_next;
    byte_beat_t              in_beat_reg;
    phase_t                  phase_reg, phase_next;
    logic [23:0]             recent_reg, recent_next;
    logic [2:0]              plen_reg, plen_next;
    logic [7:0]              hdr_reg, hdr_next;
    logic [LENGTH_WIDTH-1:0] count_reg, count_next;
    logic [1:0]              fill_reg, fill_next;
    logic [31:0]             offset_reg, offset_next;
    logic [31:0]             pos_reg, pos_next;
    logic [31:0]             units_reg, units_next;

    logic              fire;
    logic              accept;
    logic [7:0]        b;
    logic              eos;
    logic              is_one;
    logic              m4;
    logic              m3;
    logic [HELD_W-1:0] held;
    logic [HELD_W-1:0] len_raw;
    logic [2:0]        plen_new;
    logic [31:0]       offset_new;
    push_t             push_w;

    assign fire         = in_valid_reg && room;
    assign stream.ready = !in_valid_reg || fire;
    assign accept       = stream.valid && stream.ready;

    assign b      = in_beat_reg.data_byte;
    assign eos    = in_beat_reg.end_of_stream;
    assign is_one = (b == START_BYTE);
    assign m4     = (recent_reg == 24'h000000) && is_one;
    assign m3     = !m4 && (recent_reg[15:0] == 16'h0000) && is_one;
    assign held   = {1'b0, count_reg} + HELD_W'(fill_reg);

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        recent_next = recent_reg;
        plen_next   = plen_reg;
        hdr_next    = hdr_reg;
        count_next  = count_reg;
        fill_next   = fill_reg;
        offset_next = offset_reg;
        pos_next    = pos_reg;
        units_next  = units_reg;
        push_w      = '0;
        len_raw     = '0;
        plen_new    = PLEN_3;
        offset_new  = '0;

        if (fire)
        begin
            unique case (phase_reg)
                PH_AWAIT:
                begin
                    pos_next = pos_reg + 32'd1;
                    plen_new = '0;
                    if (pos_reg == 32'd2 && recent_reg[15:0] == 16'h0000 && is_one)
                    begin
                        plen_new = PLEN_3;
                    end
                    else if (pos_reg == 32'd3 && recent_reg == 24'h000000 && is_one)
                    begin
                        plen_new = PLEN_4;
                    end
                    if (plen_new != '0)
                    begin
                        phase_next  = PH_UNIT;
                        offset_next = '0;
                        plen_next   = plen_new;
                        count_next  = '0;
                        fill_next   = '0;
                        hdr_next    = '0;
                        recent_next = RECENT_RESET;
                        if (eos)
                        begin
                            push_w.n    = 2'd1;
                            push_w.rec0 = make_rec(units_reg, 32'd0, plen_new, '0, 8'h00);
                            push_w.rec0.last_of_run = 1'b1;
                            units_next  = units_reg + 32'd1;
                            phase_next  = PH_STOP;
                        end
                    end
                    else if (pos_reg >= 32'd3 || eos)
                    begin
                        push_w.n                 = 2'd1;
                        push_w.rec0.stream_error = 1'b1;
                        push_w.rec0.last_of_run  = 1'b1;
                        phase_next               = PH_STOP;
                    end
                    else
                    begin
                        recent_next = {recent_reg[15:0], b};
                    end
                end
                PH_UNIT:
                begin
                    pos_next = pos_reg + 32'd1;
                    if (m4 || m3)
                    begin
                        if (m4)
                        begin
                            plen_new   = PLEN_4;
                            offset_new = pos_reg - 32'd3;
                            len_raw    = (held >= HELD_W'(3)) ? held - HELD_W'(3) : '0;
                        end
                        else
                        begin
                            plen_new   = PLEN_3;
                            offset_new = pos_reg - 32'd2;
                            len_raw    = (held >= HELD_W'(2)) ? held - HELD_W'(2) : '0;
                        end
                        push_w.rec0 = make_rec(units_reg, offset_reg, plen_reg,
                                               sat_len(len_raw), hdr_reg);
                        offset_next = offset_new;
                        plen_next   = plen_new;
                        count_next  = '0;
                        fill_next   = '0;
                        hdr_next    = '0;
                        recent_next = RECENT_RESET;
                        if (eos)
                        begin
                            push_w.n    = 2'd2;
                            push_w.rec1 = make_rec(units_reg + 32'd1, offset_new, plen_new,
                                                   '0, 8'h00);
                            push_w.rec1.last_of_run = 1'b1;
                            units_next  = units_reg + 32'd2;
                            phase_next  = PH_STOP;
                        end
                        else
                        begin
                            push_w.n                = 2'd1;
                            push_w.rec0.last_of_run = 1'b1;
                            units_next              = units_reg + 32'd1;
                        end
                    end
                    else if (eos)
                    begin
                        push_w.n    = 2'd1;
                        push_w.rec0 = make_rec(units_reg, offset_reg, plen_reg,
                                               sat_len(held + HELD_W'(1)),
                                               (held == '0) ? b : hdr_reg);
                        push_w.rec0.last_of_run = 1'b1;
                        units_next  = units_reg + 32'd1;
                        phase_next  = PH_STOP;
                    end
                    else
                    begin
                        if (held == '0)
                        begin
                            hdr_next = b;
                        end
                        if (fill_reg != 2'd3)
                        begin
                            fill_next = fill_reg + 2'd1;
                        end
                        else
                        begin
                            count_next = sat_len({1'b0, count_reg} + HELD_W'(1));
                        end
                        recent_next = {recent_reg[15:0], b};
                    end
                end
                PH_STOP:
                begin
                    phase_next = PH_STOP;
                end
                default:
                begin
                    phase_next = PH_STOP;
                end
            endcase
        end
    end

    assign push = push_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            phase_reg    <= PH_AWAIT;
            recent_reg   <= RECENT_RESET;
            plen_reg     <= PLEN_3;
            hdr_reg      <= '0;
            count_reg    <= '0;
            fill_reg     <= '0;
            offset_reg   <= '0;
            pos_reg      <= '0;
            units_reg    <= '0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            phase_reg    <= phase_next;
            recent_reg   <= recent_next;
            plen_reg     <= plen_next;
            hdr_reg      <= hdr_next;
            count_reg    <= count_next;
            fill_reg     <= fill_next;
            offset_reg   <= offset_next;
            pos_reg      <= pos_next;
            units_reg    <= units_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_beat_reg <= stream.data;
        end
    end

endmodule

>>> src/anxb_out_queue.sv
// three-entry result queue taking up to two records per cycle
// depends on anxb_pkg and anxb_rec_if
module anxb_out_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  anxb_pkg::push_t push,
    output logic            room,
    anxb_rec_if.source      units
);
    import anxb_pkg::*;

    rec_t       mem_reg [QUEUE_DEPTH];
    logic [1:0] head_reg, head_next;
    logic [1:0] count_reg, count_next;
    logic [1:0] tail0;
    logic [1:0] tail1;
    logic       pop;

    function automatic logic [1:0] idx_add(input logic [1:0] a, input logic [1:0] d);
        logic [2:0] s;
        s = {1'b0, a} + {1'b0, d};
        if (s >= {1'b0, QUEUE_DEPTH})
        begin
            s = s - {1'b0, QUEUE_DEPTH};
        end
        return s[1:0];
    endfunction

    assign room        = count_reg <= 2'd1;
    assign units.valid = count_reg != 2'd0;
    assign units.data  = mem_reg[head_reg];
    assign pop         = units.valid && units.ready;
    assign tail0       = idx_add(head_reg, count_reg);
    assign tail1       = idx_add(tail0, 2'd1);

    always_comb
    begin
        head_next  = pop ? idx_add(head_reg, 2'd1) : head_reg;
        count_next = count_reg + push.n - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
        begin
            mem_reg[tail0] <= push.rec0;
        end
        if (push.n == 2'd2)
        begin
            mem_reg[tail1] <= push.rec1;
        end
    end

endmodule
